FILE: rtl/core/cpu8_pkg.sv
// ----------------------------------------------------------------------------
// cpu8_pkg
// Types and constants shared by the 8-bit execute unit: instruction classes,
// ALU operation codes, flag positions and the layout of a decoded instruction.
// ----------------------------------------------------------------------------
package cpu8_pkg;

    typedef enum logic [1:0] {
        OPC_ALU   = 2'd0,
        OPC_JUMP  = 2'd1,
        OPC_LOAD  = 2'd2,
        OPC_STORE = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        ALU_CLR  = 5'd0,
        ALU_MOV  = 5'd1,
        ALU_AND  = 5'd2,
        ALU_OR   = 5'd3,
        ALU_XOR  = 5'd4,
        ALU_ADD  = 5'd5,
        ALU_ADC  = 5'd6,
        ALU_SUB  = 5'd7,
        ALU_SBB  = 5'd8,
        ALU_TEST = 5'd9,
        ALU_INC  = 5'd10,
        ALU_DEC  = 5'd11,
        ALU_NOT  = 5'd12,
        ALU_NEG  = 5'd13,
        ALU_RND  = 5'd14,
        ALU_SHL  = 5'd15,
        ALU_SHR  = 5'd16,
        ALU_SAR  = 5'd17,
        ALU_RCL  = 5'd18,
        ALU_RCR  = 5'd19
    } alu_op_t;

    // Flag bit positions, shared by the flag register, the update mask and
    // the condition selector of a jump.
    localparam int FLAG_ZERO     = 0;
    localparam int FLAG_SIGN     = 1;
    localparam int FLAG_CARRY    = 2;
    localparam int FLAG_OVERFLOW = 3;

    localparam logic [7:0] SIGN_MASK = 8'h80;

    typedef struct packed {
        logic [3:0] flag_mask;
        logic       always_jump;
        logic       cond_invert;
        logic [1:0] cond_flag;
        logic [7:0] imm_byte;
        logic       load_direct;
        logic       use_imm;
        logic       use_second;
        logic [2:0] reg_second;
        logic [2:0] reg_first;
        logic [4:0] alu_op;
        logic [1:0] opcode;
    } instr_t;

endpackage

FILE: rtl/core/cpu8_execute_unit_top.sv
// ----------------------------------------------------------------------------
// cpu8_execute_unit_top
// Execute stage of an 8-bit machine: ALU with masked flag updates, jumps,
// loads and stores against a register file and a 256-byte data memory.
// ----------------------------------------------------------------------------
// The unit takes one decoded instruction per clock cycle while the result
// side does not stall it, and gives exactly one result transaction for
// each. An accepted instruction is held in an input register together with
// its register file operands and the data memory word that a load would
// read, all captured at acceptance; from that register the ALU, the jump
// test and the load/store selection run, and the result register is loaded
// when the output is free. Results of the instruction ahead are forwarded
// into the operand and memory reads, so dependent instructions still issue
// back to back; the cycle is set by that forwarding path from the ALU into
// the load address and the memory read. The data memory and the register
// file read as zero after reset (the memory through one valid bit per
// entry), so no clearing pass is needed and the unit is ready at once.
// Backpressure on the result side stalls the unit with no loss.
module cpu8_execute_unit_top
    import cpu8_pkg::*;
#(
    parameter int NUM_REGS  = 8,
    parameter int MEM_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // alu_op[4:0], reg_first[7:5], reg_second[10:8], use_second[11],
    // use_imm[12], load_direct[13], imm_byte[21:14], cond_flag[23:22],
    // cond_invert[24], always_jump[25], flag_mask[29:26], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // jump_taken[0], jump_target[8:1], write_value[16:9], flags_now[20:17],
    // zero[23:21]
    output logic [23:0] m_axis_tdata
);

    localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Architectural state
    logic [7:0]  rf_reg [NUM_REGS];
    logic [3:0]  flag_reg;
    logic [7:0]  data_mem [MEM_DEPTH];
    logic        mem_valid_reg [MEM_DEPTH];

    // Input register
    logic        in_v_reg;
    instr_t      item_reg;
    logic [7:0]  rd1_reg;
    logic [7:0]  rd2_reg;
    logic [7:0]  mem_word_reg;
    logic        mem_ok_reg;
    logic        mem_fwd_reg;
    logic [7:0]  mem_fwd_data_reg;

    // Result register
    logic        out_v_reg;
    logic        out_taken_reg;
    logic [7:0]  out_target_reg;
    logic [7:0]  out_wval_reg;
    logic [3:0]  out_flags_reg;

    instr_t      in_item;
    logic        advance;
    logic        accept;

    // Execute signals
    opcode_t     ex_opc;
    logic [7:0]  ex_a;
    logic [7:0]  ex_b;
    logic [7:0]  ex_ob;
    logic        ex_carry_in;
    logic [8:0]  ex_r;
    logic        ex_subclass;
    logic [3:0]  ex_nf;
    logic [3:0]  flag_next;
    logic [7:0]  ex_mem_val;
    logic [7:0]  ex_src;
    logic [7:0]  ex_dest;
    logic        ex_cond;
    logic        ex_taken;
    logic [7:0]  ex_target;
    logic [7:0]  ex_wval;
    logic [7:0]  ex_st_addr;
    logic        reg_we;
    logic        mem_we;

    // Operand capture
    logic [7:0]  rd1_next;
    logic [7:0]  rd2_next;
    logic [7:0]  ld_addr;
    logic        ld_in_range;
    logic        mem_ok_next;
    logic        mem_fwd_next;

    assign in_item       = instr_t'({s_axis_tdata[29:0], s_axis_tuser});
    assign advance       = in_v_reg && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = !in_v_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {3'b000, out_flags_reg, out_wval_reg, out_target_reg,
                            out_taken_reg};

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    always_comb
    begin
        ex_opc      = opcode_t'(item_reg.opcode);
        ex_a        = rd1_reg;
        ex_b        = item_reg.use_second ? rd2_reg : 8'h00;
        ex_ob       = ex_b;
        ex_carry_in = flag_reg[FLAG_CARRY];
        ex_subclass = 1'b0;
        case (alu_op_t'(item_reg.alu_op))
            ALU_CLR:  ex_r = 9'h000;
            ALU_MOV:  ex_r = {1'b0, ex_b};
            ALU_AND:  ex_r = {1'b0, ex_a & ex_b};
            ALU_OR:   ex_r = {1'b0, ex_a | ex_b};
            ALU_XOR:  ex_r = {1'b0, ex_a ^ ex_b};
            ALU_ADD:  ex_r = {1'b0, ex_a} + {1'b0, ex_b};
            ALU_ADC:  ex_r = {1'b0, ex_a} + {1'b0, ex_b} + {8'h00, ex_carry_in};
            ALU_SUB:
            begin
                ex_r        = {1'b0, ex_a} - {1'b0, ex_b};
                ex_subclass = 1'b1;
            end
            ALU_SBB:
            begin
                ex_r        = {1'b0, ex_a} - {1'b0, ex_b} - {8'h00, ex_carry_in};
                ex_subclass = 1'b1;
            end
            ALU_TEST:
            begin
                ex_r        = {1'b0, ex_a};
                ex_subclass = 1'b1;
            end
            ALU_INC:
            begin
                ex_r  = {1'b0, ex_a} + 9'd1;
                ex_ob = 8'h01;
            end
            ALU_DEC:
            begin
                ex_r        = {1'b0, ex_a} - 9'd1;
                ex_ob       = 8'h01;
                ex_subclass = 1'b1;
            end
            ALU_NOT:  ex_r = {1'b0, ~ex_a};
            ALU_NEG:  ex_r = {1'b0, ex_a ^ SIGN_MASK};
            ALU_RND:  ex_r = 9'h000;
            ALU_SHL:  ex_r = {1'b0, ex_a[6:0], 1'b0};
            ALU_SHR:  ex_r = {2'b00, ex_a[7:1]};
            ALU_SAR:  ex_r = {1'b0, ex_a[7], ex_a[7:1]};
            ALU_RCL:  ex_r = {1'b0, ex_a[6:0], ex_carry_in};
            ALU_RCR:  ex_r = {1'b0, ex_carry_in, ex_a[7:1]};
            default:  ex_r = {1'b0, ex_a};
        endcase

        ex_nf[FLAG_ZERO]  = (ex_r == 9'h000);
        ex_nf[FLAG_SIGN]  = ex_r[7];
        ex_nf[FLAG_CARRY] = ex_r[8];
        if (ex_subclass)
        begin
            ex_nf[FLAG_OVERFLOW] = (ex_a[7] ^ ex_ob[7]) & (ex_a[7] ^ ex_r[7]);
        end
        else
        begin
            ex_nf[FLAG_OVERFLOW] = (ex_a[7] ^ ex_r[7]) & (ex_ob[7] ^ ex_r[7]);
        end

        // Load source and the memory word, forwarded from a store ahead.
        ex_src = item_reg.use_imm ? item_reg.imm_byte : rd2_reg;
        if (mem_fwd_reg)
        begin
            ex_mem_val = mem_fwd_data_reg;
        end
        else
        begin
            ex_mem_val = mem_ok_reg ? mem_word_reg : 8'h00;
        end

        ex_dest    = item_reg.use_imm ? item_reg.imm_byte : rd1_reg;
        ex_cond    = flag_reg[item_reg.cond_flag] ^ item_reg.cond_invert;
        ex_st_addr = ex_dest;

        flag_next = flag_reg;
        ex_taken  = 1'b0;
        ex_target = 8'h00;
        ex_wval   = 8'h00;
        reg_we    = 1'b0;
        mem_we    = 1'b0;
        case (ex_opc)
            OPC_ALU:
            begin
                flag_next = (flag_reg & ~item_reg.flag_mask) | (ex_nf & item_reg.flag_mask);
                ex_wval   = ex_r[7:0];
                reg_we    = 1'b1;
            end
            OPC_JUMP:
            begin
                ex_taken  = item_reg.always_jump || ex_cond;
                ex_target = ex_taken ? ex_dest : 8'h00;
            end
            OPC_LOAD:
            begin
                ex_wval = item_reg.load_direct ? ex_src : ex_mem_val;
                reg_we  = 1'b1;
            end
            OPC_STORE:
            begin
                ex_wval = rd2_reg;
                mem_we  = (32'(ex_st_addr) < MEM_DEPTH);
            end
            default:
            begin
                ex_wval = 8'h00;
            end
        endcase
        reg_we = reg_we && advance && (32'(item_reg.reg_first) < NUM_REGS);
        mem_we = mem_we && advance;
    end

    // ------------------------------------------------------------------
    // Operand capture with forwarding from the instruction now retiring
    // ------------------------------------------------------------------
    always_comb
    begin
        if (reg_we && (in_item.reg_first == item_reg.reg_first))
        begin
            rd1_next = ex_wval;
        end
        else if (32'(in_item.reg_first) < NUM_REGS)
        begin
            rd1_next = rf_reg[REG_AW'(in_item.reg_first)];
        end
        else
        begin
            rd1_next = 8'h00;
        end

        if (reg_we && (in_item.reg_second == item_reg.reg_first))
        begin
            rd2_next = ex_wval;
        end
        else if (32'(in_item.reg_second) < NUM_REGS)
        begin
            rd2_next = rf_reg[REG_AW'(in_item.reg_second)];
        end
        else
        begin
            rd2_next = 8'h00;
        end

        ld_addr      = in_item.use_imm ? in_item.imm_byte : rd2_next;
        ld_in_range  = (32'(ld_addr) < MEM_DEPTH);
        mem_ok_next  = ld_in_range && mem_valid_reg[MEM_AW'(ld_addr)];
        mem_fwd_next = mem_we && (ld_addr == ex_st_addr);
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            flag_reg    <= 4'h0;
            mem_ok_reg  <= 1'b0;
            mem_fwd_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= 8'h00;
            end
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                mem_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (accept)
            begin
                in_v_reg    <= 1'b1;
                mem_ok_reg  <= mem_ok_next;
                mem_fwd_reg <= mem_fwd_next;
            end
            else if (advance)
            begin
                in_v_reg <= 1'b0;
            end

            if (advance)
            begin
                out_v_reg <= 1'b1;
                flag_reg  <= flag_next;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end

            if (reg_we)
            begin
                rf_reg[REG_AW'(item_reg.reg_first)] <= ex_wval;
            end
            if (mem_we)
            begin
                mem_valid_reg[MEM_AW'(ex_st_addr)] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg         <= in_item;
            rd1_reg          <= rd1_next;
            rd2_reg          <= rd2_next;
            mem_fwd_data_reg <= ex_wval;
        end
        if (advance)
        begin
            out_taken_reg  <= ex_taken;
            out_target_reg <= ex_target;
            out_wval_reg   <= ex_wval;
            out_flags_reg  <= flag_next;
        end
    end

    // Data memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[MEM_AW'(ex_st_addr)] <= ex_wval;
        end
        if (accept)
        begin
            mem_word_reg <= data_mem[MEM_AW'(ld_addr)];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flag_reg))
        else $error("flags changed without a retiring instruction");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && out_v_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_retire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_v_reg)
        else $error("retired instruction produced no result");

    a_untaken_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_taken_reg) |-> (out_target_reg == 8'h00))
        else $error("jump target set for an instruction that did not jump");

    a_store_only_writes_mem: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (advance && (ex_opc == OPC_STORE) && !reg_we))
        else $error("memory written by an instruction other than a store");

endmodule
